// ===== rtl/rxr_pkg.sv =====
package rxr_pkg;

  typedef enum logic [2:0] {
    ACT_WIRE_PUSH   = 3'd0,
    ACT_STREAM_PUSH = 3'd1,
    ACT_REPLY_BYTE  = 3'd2,
    ACT_POP         = 3'd3,
    ACT_PEEK        = 3'd4,
    ACT_CLEAR       = 3'd5
  } action_t;

  localparam logic [7:0] BREAK_BYTE = 8'h03;

  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned IN_TUSER_W  = 4;
  localparam int unsigned OUT_TDATA_W = 32;

endpackage

// ===== rtl/rxr_ram.sv =====
module rxr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/rx_ring_with_held_reply_unit.sv =====
// Receive byte ring with a held terminal reply. Each input beat carries one action: wire push,
// stream push, reply byte, pop, peek or clear; each produces exactly one result beat. The ring
// keeps one slot empty and drops bytes that arrive while it is full; a wire push of 0x03 flags a
// break even when the byte is dropped. Reply bytes collect in a hold buffer, and a pop or peek
// on an empty ring first moves the held bytes into the ring. Both stores are single-port-write
// RAMs with a registered read. A pop or peek that first moves held bytes reads each byte from
// the hold RAM and then writes it into the ring; the pop or peek then reads the ring. A new beat
// is taken only once the previous result is loaded into the result register, and output stalls
// hold the unit while the result register is full.
module rx_ring_with_held_reply_unit #(
  parameter int unsigned RING_DEPTH = 256,
  parameter int unsigned HOLD_DEPTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic                              cfg_wr_data,   // reply_suppressed
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [rxr_pkg::IN_TDATA_W-1:0]    in_tdata,      // data_byte, reply_length
  input  logic [rxr_pkg::IN_TUSER_W-1:0]    in_tuser,      // action, reply_first
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rxr_pkg::OUT_TDATA_W-1:0]   out_tdata      // read_byte, byte_valid,
                                                           // break_seen, free_space,
                                                           // reply_held, reply_dropped, zeros
);

  import rxr_pkg::*;

  localparam int unsigned RING_AW = $clog2(RING_DEPTH);
  localparam int unsigned HOLD_AW = $clog2(HOLD_DEPTH);
  localparam int unsigned HCW     = $clog2(HOLD_DEPTH + 1);
  localparam int unsigned FSW     = (RING_AW + 1 > 8) ? RING_AW + 1 : 8;
  localparam int unsigned HSW     = (HCW > 6) ? HCW : 6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_PRD,
    S_PWR,
    S_RDISSUE,
    S_RDWAIT,
    S_FIN
  } state_t;

  state_t                  state_r, state_nxt;
  action_t                 act_r, act_nxt;
  logic [7:0]              data_r, data_nxt;
  logic                    first_r, first_nxt;
  logic [7:0]              len_r, len_nxt;
  logic                    suppressed_r, suppressed_nxt;
  logic [RING_AW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [RING_AW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [HCW-1:0]          hold_count_r, hold_count_nxt;
  logic                    accepting_r, accepting_nxt;
  logic [HCW-1:0]          promo_idx_r, promo_idx_nxt;
  logic [7:0]              res_byte_r, res_byte_nxt;
  logic                    res_valid_r, res_valid_nxt;
  logic                    res_brk_r, res_brk_nxt;
  logic                    res_drop_r, res_drop_nxt;
  logic                    out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0]  out_tdata_r, out_tdata_nxt;

  logic                    ring_we;
  logic [7:0]              ring_wdata;
  logic [7:0]              ring_rdata;
  logic                    hold_we;
  logic [7:0]              hold_rdata;

  logic                    out_free;
  logic                    in_take;
  logic                    ring_empty;
  logic                    ring_full;
  logic [RING_AW-1:0]      wr_ptr_inc;
  logic [RING_AW-1:0]      rd_ptr_inc;
  logic [FSW-1:0]          free_ext;
  logic [7:0]              free_space;
  logic [HSW-1:0]          held_ext;
  logic [5:0]              reply_held;
  logic [8:0]              fit_sum;
  logic                    fit_refuse;
  logic [HCW-1:0]          promo_idx_inc;

  function automatic logic [RING_AW-1:0] ring_next(input logic [RING_AW-1:0] ptr);
    ring_next = (ptr == RING_AW'(RING_DEPTH - 1)) ? '0 : ptr + RING_AW'(1);
  endfunction

  rxr_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring_ram (
    .clk     (clk),
    .wr_en   (ring_we),
    .wr_addr (wr_ptr_r),
    .wr_data (ring_wdata),
    .rd_addr (rd_ptr_r),
    .rd_data (ring_rdata)
  );

  rxr_ram #(
    .WIDTH (8),
    .DEPTH (HOLD_DEPTH)
  ) u_hold_ram (
    .clk     (clk),
    .wr_en   (hold_we),
    .wr_addr (hold_count_r[HOLD_AW-1:0]),
    .wr_data (data_r),
    .rd_addr (promo_idx_r[HOLD_AW-1:0]),
    .rd_data (hold_rdata)
  );

  assign wr_ptr_inc    = ring_next(wr_ptr_r);
  assign rd_ptr_inc    = ring_next(rd_ptr_r);
  assign ring_empty    = (wr_ptr_r == rd_ptr_r);
  assign ring_full     = (wr_ptr_inc == rd_ptr_r);
  assign promo_idx_inc = promo_idx_r + HCW'(1);

  always_comb begin
    if (rd_ptr_r > wr_ptr_r) begin
      free_ext = FSW'(rd_ptr_r) - FSW'(wr_ptr_r) - FSW'(1);
    end else begin
      free_ext = FSW'(rd_ptr_r) + FSW'(RING_DEPTH) - FSW'(wr_ptr_r) - FSW'(1);
    end
    free_space = (free_ext > FSW'(255)) ? 8'hFF : free_ext[7:0];
    held_ext   = HSW'(hold_count_r);
    reply_held = (held_ext > HSW'(63)) ? 6'd63 : held_ext[5:0];
  end

  assign fit_sum    = 9'(hold_count_r) + 9'(len_r);
  assign fit_refuse = suppressed_r || (len_r == 8'd0) || (9'(len_r) > 9'(HOLD_DEPTH)) ||
                      (fit_sum > 9'(HOLD_DEPTH));

  assign out_free  = !out_tvalid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) || ((state_r == S_FIN) && out_free);
  assign in_take   = in_tvalid && in_tready;

  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    data_nxt       = data_r;
    first_nxt      = first_r;
    len_nxt        = len_r;
    suppressed_nxt = cfg_wr_en ? cfg_wr_data : suppressed_r;
    wr_ptr_nxt     = wr_ptr_r;
    rd_ptr_nxt     = rd_ptr_r;
    hold_count_nxt = hold_count_r;
    accepting_nxt  = accepting_r;
    promo_idx_nxt  = promo_idx_r;
    res_byte_nxt   = res_byte_r;
    res_valid_nxt  = res_valid_r;
    res_brk_nxt    = res_brk_r;
    res_drop_nxt   = res_drop_r;
    out_tvalid_nxt = out_tready ? 1'b0 : out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    ring_we        = 1'b0;
    ring_wdata     = data_r;
    hold_we        = 1'b0;

    if (in_take) begin
      act_nxt   = action_t'(in_tuser[2:0]);
      first_nxt = in_tuser[3];
      data_nxt  = in_tdata[7:0];
      len_nxt   = in_tdata[15:8];
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_byte_nxt  = 8'd0;
        res_valid_nxt = 1'b0;
        res_brk_nxt   = 1'b0;
        res_drop_nxt  = 1'b0;
        state_nxt     = S_FIN;
        case (act_r) inside
          ACT_WIRE_PUSH, ACT_STREAM_PUSH: begin
            res_brk_nxt = (act_r == ACT_WIRE_PUSH) && (data_r == BREAK_BYTE);
            if (!ring_full) begin
              ring_we    = 1'b1;
              wr_ptr_nxt = wr_ptr_inc;
            end
          end
          ACT_REPLY_BYTE: begin
            if (first_r) begin
              if (fit_refuse) begin
                res_drop_nxt  = 1'b1;
                accepting_nxt = 1'b0;
              end else begin
                accepting_nxt  = 1'b1;
                hold_we        = 1'b1;
                hold_count_nxt = hold_count_r + HCW'(1);
              end
            end else if (!accepting_r || (hold_count_r >= HCW'(HOLD_DEPTH))) begin
              res_drop_nxt = 1'b1;
            end else begin
              hold_we        = 1'b1;
              hold_count_nxt = hold_count_r + HCW'(1);
            end
          end
          ACT_POP, ACT_PEEK: begin
            if ((hold_count_r != '0) && ring_empty) begin
              promo_idx_nxt = '0;
              state_nxt     = S_PRD;
            end else if (!ring_empty) begin
              state_nxt = S_RDWAIT;
            end
          end
          ACT_CLEAR: begin
            wr_ptr_nxt     = '0;
            rd_ptr_nxt     = '0;
            hold_count_nxt = '0;
            accepting_nxt  = 1'b0;
          end
          default: begin
          end
        endcase
      end
      S_PRD: begin
        state_nxt = S_PWR;
      end
      S_PWR: begin
        ring_wdata    = hold_rdata;
        promo_idx_nxt = promo_idx_inc;
        if (!ring_full) begin
          ring_we    = 1'b1;
          wr_ptr_nxt = wr_ptr_inc;
        end
        if (promo_idx_inc == hold_count_r) begin
          hold_count_nxt = '0;
          state_nxt      = S_RDISSUE;
        end else begin
          state_nxt = S_PRD;
        end
      end
      S_RDISSUE: begin
        state_nxt = S_RDWAIT;
      end
      S_RDWAIT: begin
        res_byte_nxt  = ring_rdata;
        res_valid_nxt = 1'b1;
        if (act_r == ACT_POP) begin
          rd_ptr_nxt = rd_ptr_inc;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {7'd0, res_drop_r, reply_held, free_space,
                            res_brk_r, res_valid_r, res_byte_r};
          state_nxt      = in_tvalid ? S_EXEC : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      suppressed_r <= 1'b0;
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      hold_count_r <= '0;
      accepting_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      suppressed_r <= suppressed_nxt;
      wr_ptr_r     <= wr_ptr_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
      hold_count_r <= hold_count_nxt;
      accepting_r  <= accepting_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    act_r       <= act_nxt;
    data_r      <= data_nxt;
    first_r     <= first_nxt;
    len_r       <= len_nxt;
    promo_idx_r <= promo_idx_nxt;
    res_byte_r  <= res_byte_nxt;
    res_valid_r <= res_valid_nxt;
    res_brk_r   <= res_brk_nxt;
    res_drop_r  <= res_drop_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef SYNTHESIS
  a_hold_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hold_count_r <= HCW'(HOLD_DEPTH))
    else $error("hold count beyond hold buffer depth");

  a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
    ring_we |-> !ring_full)
    else $error("ring written while full");

  a_promo_drained: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RDISSUE |-> hold_count_r == '0 && !ring_empty)
    else $error("promotion left held bytes or an empty ring");

  a_take_executes: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_EXEC)
    else $error("accepted beat not executed");
`endif

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import rxr_pkg::*;

  localparam int unsigned RING_DEPTH = 256;
  localparam int unsigned HOLD_DEPTH = 32;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam logic [2:0] ACT_UNUSED_6 = 3'd6;
  localparam logic [2:0] ACT_UNUSED_7 = 3'd7;

  typedef struct packed {
    logic       reply_first;
    logic [2:0] action;
    logic [7:0] reply_length;
    logic [7:0] data_byte;
  } rx_item_t;

  typedef struct packed {
    logic       reply_dropped;
    logic [5:0] reply_held;
    logic [7:0] free_space;
    logic       break_seen;
    logic       byte_valid;
    logic [7:0] read_byte;
  } rx_status_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic                   cfg_wr_data = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // data_byte, reply_length
  logic [IN_TUSER_W-1:0]  in_tuser = '0;   // action, reply_first
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // read_byte, byte_valid, break_seen,
                                           // free_space, reply_held, reply_dropped, zeros

  rx_item_t   pending_items[$];
  rx_status_t expected_status[$];
  rx_item_t   beat_in_flight;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          long_hold_req = 1'b0;
  bit          long_hold_started = 1'b0;
  int unsigned long_hold_left = 0;
  int unsigned cycle_count = 0;
  int unsigned queued_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned checked_count = 0;
  int unsigned action_count[8];
  int unsigned break_count = 0;
  int unsigned refused_count = 0;
  int unsigned full_ring_count = 0;
  int unsigned promotion_count = 0;

  logic [7:0]  ring_mem[RING_DEPTH];
  logic [7:0]  hold_mem[HOLD_DEPTH];
  int unsigned ring_wr = 0;
  int unsigned ring_rd = 0;
  int unsigned hold_cnt = 0;
  bit          reply_open = 1'b0;
  bit          replies_suppressed = 1'b0;

  rx_ring_with_held_reply_unit #(
    .RING_DEPTH(RING_DEPTH),
    .HOLD_DEPTH(HOLD_DEPTH)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function void ring_put(logic [7:0] b);
    int unsigned nxt;
    nxt = (ring_wr + 1) % RING_DEPTH;
    if (nxt != ring_rd) begin
      ring_mem[ring_wr] = b;
      ring_wr = nxt;
    end
  endfunction

  function bit hold_reply_byte(rx_item_t it);
    if (it.reply_first) begin
      if (replies_suppressed || it.reply_length == 0 || it.reply_length > HOLD_DEPTH ||
          hold_cnt + it.reply_length > HOLD_DEPTH) begin
        reply_open = 1'b0;
        return 1'b0;
      end
      reply_open = 1'b1;
    end else if (!reply_open || hold_cnt >= HOLD_DEPTH) begin
      return 1'b0;
    end
    hold_mem[hold_cnt] = it.data_byte;
    hold_cnt++;
    return 1'b1;
  endfunction

  function rx_status_t predict_status(rx_item_t it);
    rx_status_t r;
    int unsigned i;
    int unsigned free_slots;
    r = '0;
    case (it.action) inside
      ACT_WIRE_PUSH: begin
        r.break_seen = (it.data_byte == BREAK_BYTE);
        ring_put(it.data_byte);
      end
      ACT_STREAM_PUSH: ring_put(it.data_byte);
      ACT_REPLY_BYTE:  r.reply_dropped = !hold_reply_byte(it);
      ACT_POP, ACT_PEEK: begin
        if (hold_cnt != 0 && ring_wr == ring_rd) begin
          for (i = 0; i < hold_cnt; i++) ring_put(hold_mem[i]);
          hold_cnt = 0;
          promotion_count++;
        end
        if (ring_wr != ring_rd) begin
          r.read_byte = ring_mem[ring_rd];
          r.byte_valid = 1'b1;
          if (it.action == ACT_POP) ring_rd = (ring_rd + 1) % RING_DEPTH;
        end
      end
      ACT_CLEAR: begin
        ring_wr = 0;
        ring_rd = 0;
        hold_cnt = 0;
        reply_open = 1'b0;
      end
      default: ;
    endcase
    free_slots = (ring_rd + RING_DEPTH - ring_wr - 1) % RING_DEPTH;
    r.free_space = (free_slots > 255) ? 8'd255 : free_slots[7:0];
    r.reply_held = (hold_cnt > 63) ? 6'd63 : hold_cnt[5:0];
    action_count[it.action]++;
    if (r.break_seen) break_count++;
    if (r.reply_dropped) refused_count++;
    if (r.free_space == 0) full_ring_count++;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) expected_status.push_back(predict_status(beat_in_flight));
      if (!in_tvalid || in_tready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          beat_in_flight = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {beat_in_flight.reply_length, beat_in_flight.data_byte};
          in_tuser <= {beat_in_flight.reply_first, beat_in_flight.action};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (long_hold_req && !long_hold_started) begin
      long_hold_started <= 1'b1;
      long_hold_left <= LONG_HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (long_hold_left != 0) begin
      long_hold_left <= long_hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    rx_status_t got;
    rx_status_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(rx_status_t)-1:0];
      if (expected_status.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
      end else begin
        want = expected_status.pop_front();
        checked_count++;
        check_field("read_byte", want.read_byte, got.read_byte);
        check_field("byte_valid", want.byte_valid, got.byte_valid);
        check_field("break_seen", want.break_seen, got.break_seen);
        check_field("free_space", want.free_space, got.free_space);
        check_field("reply_held", want.reply_held, got.reply_held);
        check_field("reply_dropped", want.reply_dropped, got.reply_dropped);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic add_item(logic [2:0] action, logic [7:0] data_byte, logic reply_first,
                          logic [7:0] reply_length);
    rx_item_t it;
    it.action = action;
    it.data_byte = data_byte;
    it.reply_first = reply_first;
    it.reply_length = reply_length;
    pending_items.push_back(it);
    if (action != ACT_UNUSED_6 && action != ACT_UNUSED_7) queued_count++;
  endtask

  function automatic logic [7:0] push_data();
    return ($urandom_range(4) == 0) ? BREAK_BYTE : 8'($urandom);
  endfunction

  task automatic add_pushes(int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) begin
      add_item($urandom_range(1) ? ACT_WIRE_PUSH : ACT_STREAM_PUSH, push_data(),
               1'($urandom), 8'($urandom));
    end
  endtask

  task automatic add_reply_sequence();
    int unsigned pick;
    int unsigned len;
    int unsigned n_bytes;
    int unsigned i;
    pick = $urandom_range(9);
    if (pick == 0) len = 0;
    else if (pick == 1) len = $urandom_range(255, 33);
    else if (pick < 7) len = $urandom_range(6, 1);
    else len = $urandom_range(32, 7);
    if (len == 0 || len > HOLD_DEPTH) n_bytes = $urandom_range(3, 1);
    else n_bytes = len;
    if ($urandom_range(5) == 0) n_bytes += $urandom_range(3, 1);
    else if ($urandom_range(5) == 0 && n_bytes > 1) n_bytes = $urandom_range(n_bytes - 1, 1);
    for (i = 0; i < n_bytes; i++) begin
      if (i == 0) add_item(ACT_REPLY_BYTE, 8'($urandom), 1'b1, len[7:0]);
      else add_item(ACT_REPLY_BYTE, 8'($urandom), 1'b0, 8'($urandom));
      if (i != 0 && $urandom_range(11) == 0)
        add_item($urandom_range(1) ? ACT_POP : ACT_PEEK, 8'($urandom), 1'($urandom),
                 8'($urandom));
    end
  endtask

  task automatic add_random_traffic(int unsigned target);
    int unsigned stop_at;
    int unsigned kind;
    int unsigned i;
    int unsigned n;
    stop_at = queued_count + target;
    while (queued_count < stop_at) begin
      kind = $urandom_range(199);
      if (kind < 60) begin
        add_reply_sequence();
      end else if (kind < 110) begin
        add_pushes($urandom_range(8, 1));
      end else if (kind < 180) begin
        n = $urandom_range(8, 1);
        for (i = 0; i < n; i++)
          add_item(($urandom_range(3) != 0) ? ACT_POP : ACT_PEEK, 8'($urandom),
                   1'($urandom), 8'($urandom));
      end else if (kind < 190) begin
        add_item(ACT_CLEAR, 8'($urandom), 1'($urandom), 8'($urandom));
      end else if (kind < 198) begin
        add_item($urandom_range(1) ? ACT_UNUSED_6 : ACT_UNUSED_7, 8'($urandom),
                 1'($urandom), 8'($urandom));
      end else begin
        add_pushes($urandom_range(RING_DEPTH + 2, RING_DEPTH - 1));
      end
    end
  endtask

  task automatic wait_until_idle();
    while (pending_items.size() != 0 || in_tvalid || expected_status.size() != 0 ||
           long_hold_left != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_suppress(bit value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    replies_suppressed = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_phase(int unsigned sender_idle, int unsigned receiver_stall,
                           bit suppress, int unsigned n_items);
    wait_until_idle();
    send_idle_pct = sender_idle;
    recv_stall_pct = receiver_stall;
    write_suppress(suppress);
    add_random_traffic(n_items);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    write_suppress(1'b0);

    add_item(ACT_POP, 8'h00, 1'b0, 8'h00);
    add_item(ACT_PEEK, 8'h00, 1'b0, 8'h00);
    add_item(ACT_WIRE_PUSH, BREAK_BYTE, 1'b0, 8'h00);
    add_item(ACT_STREAM_PUSH, BREAK_BYTE, 1'b0, 8'h00);
    add_item(ACT_WIRE_PUSH, 8'hFF, 1'b1, 8'hFF);
    add_item(ACT_STREAM_PUSH, 8'h00, 1'b0, 8'h00);
    repeat (4) add_item(ACT_POP, 8'h00, 1'b0, 8'h00);
    add_item(ACT_PEEK, 8'hFF, 1'b1, 8'hFF);
    add_item(ACT_REPLY_BYTE, 8'h5A, 1'b1, 8'd0);
    add_item(ACT_REPLY_BYTE, 8'h5B, 1'b1, 8'd33);
    add_item(ACT_REPLY_BYTE, 8'hFF, 1'b1, 8'd255);
    add_item(ACT_REPLY_BYTE, 8'h01, 1'b0, 8'd3);
    add_item(ACT_REPLY_BYTE, 8'h11, 1'b1, 8'd3);
    add_item(ACT_REPLY_BYTE, 8'h22, 1'b0, 8'd3);
    add_item(ACT_PEEK, 8'h00, 1'b0, 8'h00);
    add_item(ACT_REPLY_BYTE, 8'h33, 1'b0, 8'd3);
    add_item(ACT_POP, 8'h00, 1'b0, 8'h00);
    add_item(ACT_CLEAR, 8'h00, 1'b0, 8'h00);
    add_item(ACT_REPLY_BYTE, 8'h44, 1'b0, 8'd3);
    add_item(ACT_UNUSED_6, 8'hFF, 1'b1, 8'hFF);
    add_item(ACT_UNUSED_7, 8'h00, 1'b0, 8'h00);
    add_item(ACT_REPLY_BYTE, 8'h80, 1'b1, 8'd32);
    add_item(ACT_PEEK, 8'h00, 1'b0, 8'h00);

    run_phase(0, 0, 1'b0, 200);
    run_phase(68, 0, 1'b1, 200);
    run_phase(0, 68, 1'b0, 200);
    run_phase(25, 25, 1'b1, 200);

    wait_until_idle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_suppress(1'b0);
    long_hold_req = 1'b1;
    add_pushes(RING_DEPTH + 4);
    add_item(ACT_WIRE_PUSH, BREAK_BYTE, 1'b0, 8'h00);
    add_random_traffic(40);

    wait_until_idle();
    repeat (80) @(posedge clk);
    $display("Checked %0d result beats: %0d pushes, %0d reply bytes, %0d pops/peeks, %0d clears.",
             checked_count, action_count[ACT_WIRE_PUSH] + action_count[ACT_STREAM_PUSH],
             action_count[ACT_REPLY_BYTE], action_count[ACT_POP] + action_count[ACT_PEEK],
             action_count[ACT_CLEAR]);
    $display("Saw %0d breaks, %0d refused reply bytes, %0d full-ring beats, %0d promotions.",
             break_count, refused_count, full_ring_count, promotion_count);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
